/* hdl/rdc_pkg.sv */
// Shared constants, types and helper functions of the radix digit converter.
`default_nettype none

package rdc_pkg;

	// Field widths
	localparam int VALUE_BITS = 31;
	localparam int RADIX_W    = 5;
	localparam int CHAR_W     = 7;
	localparam int DIGIT_W    = 4;

	// Reciprocal divide: q ~= (v * floor(2^RECIP_W / r)) >> RECIP_W, off by at most one
	localparam int RECIP_W = VALUE_BITS + 1;
	localparam int PROD_W  = VALUE_BITS + RECIP_W;
	localparam int WIDE_W  = VALUE_BITS + RADIX_W;
	localparam int REM_W   = 6;

	// Digit counter holds 0..VALUE_BITS, store index 0..VALUE_BITS-1
	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam int IDX_W = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_ERR  = 7'h00;

	localparam logic ERR_NONE  = 1'b0;
	localparam logic ERR_RADIX = 1'b1;

	// Word class decided by the front end
	typedef enum logic [2:0] {
		KIND_NUM  = 3'b001,
		KIND_ZERO = 3'b010,
		KIND_BAD  = 3'b100
	} kind_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_W-1:0]    radix;
		kind_t                 kind;
	} job_t;

	// Queue status seen by producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// ASCII glyph of one digit
	function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] g;
		if (d < DIGIT_W'(10)) begin
			g = CHAR_ZERO + CHAR_W'(d);
		end else begin
			g = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
		end
		return g;
	endfunction

	// floor(2^RECIP_W / r) for the legal radices
	function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIX_W-1:0] r);
		logic [127:0] one;
		logic [RECIP_W-1:0] m;
		one = 128'(1) << RECIP_W;
		case (r)
			5'd2:    m = RECIP_W'(one / 128'd2);
			5'd3:    m = RECIP_W'(one / 128'd3);
			5'd4:    m = RECIP_W'(one / 128'd4);
			5'd5:    m = RECIP_W'(one / 128'd5);
			5'd6:    m = RECIP_W'(one / 128'd6);
			5'd7:    m = RECIP_W'(one / 128'd7);
			5'd8:    m = RECIP_W'(one / 128'd8);
			5'd9:    m = RECIP_W'(one / 128'd9);
			5'd10:   m = RECIP_W'(one / 128'd10);
			5'd11:   m = RECIP_W'(one / 128'd11);
			5'd12:   m = RECIP_W'(one / 128'd12);
			5'd13:   m = RECIP_W'(one / 128'd13);
			5'd14:   m = RECIP_W'(one / 128'd14);
			5'd15:   m = RECIP_W'(one / 128'd15);
			5'd16:   m = RECIP_W'(one / 128'd16);
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* hdl/rdc_front.sv */
// Front end: takes request words, classifies them and pushes them into the job queue.
`default_nettype none

module rdc_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic [rdc_pkg::VALUE_BITS-1:0]  value,
	input  wire logic [rdc_pkg::RADIX_W-1:0]     radix,
	input  wire rdc_pkg::qstat_t                 qstat,
	output logic                                 push,
	output rdc_pkg::job_t                        push_job
);

	logic seen_q;

	// Stall only when the queue has no room
	assign req_stall = qstat.full;
	assign push      = req_valid && !qstat.full;

	// Zero test wins over the radix test
	always_comb begin
		push_job.value = value;
		push_job.radix = radix;
		if (value == '0) begin
			push_job.kind = rdc_pkg::KIND_ZERO;
		end else if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
			push_job.kind = rdc_pkg::KIND_BAD;
		end else begin
			push_job.kind = rdc_pkg::KIND_NUM;
		end
	end

	// Marks that at least one word has come in since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (push) begin
			seen_q <= 1'b1;
		end
	end

	a_push_mark: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> seen_q)
		else $error("front: push not recorded");

endmodule

`default_nettype wire

/* hdl/rdc_queue.sv */
// Two-entry job queue between the front end and the converter back end.
`default_nettype none

module rdc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rdc_pkg::job_t push_job,
	input  wire logic          pop,
	output rdc_pkg::job_t      pop_job,
	output rdc_pkg::qstat_t    qstat
);

	rdc_pkg::job_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign pop_job     = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue: push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue: pop while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue: count out of range");

endmodule

`default_nettype wire

/* hdl/rdc_back.sv */
// Back end: serial digit extraction by reciprocal divide, then reversed character output.
`default_nettype none

module rdc_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rdc_pkg::qstat_t               qstat,
	input  wire rdc_pkg::job_t                 pop_job,
	output logic                               pop,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [rdc_pkg::CHAR_W-1:0]         digit_char,
	output logic                               is_last,
	output logic                               error_code
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_REM  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [rdc_pkg::VALUE_BITS-1:0]  quot_q;
	logic [rdc_pkg::RADIX_W-1:0]     radix_q;
	logic [rdc_pkg::PROD_W-1:0]      prod_q;
	logic [rdc_pkg::CNT_W-1:0]       cnt_q;
	logic [rdc_pkg::IDX_W-1:0]       idx_q;
	logic                            special_q;
	logic [rdc_pkg::CHAR_W-1:0]      spec_char_q;
	logic                            spec_err_q;
	logic [rdc_pkg::DIGIT_W-1:0]     store_q [rdc_pkg::VALUE_BITS];

	logic                            rsp_valid_q;
	logic [rdc_pkg::CHAR_W-1:0]      char_q;
	logic                            last_q;
	logic                            err_q;

	logic [rdc_pkg::VALUE_BITS-1:0]  q_est;
	logic [rdc_pkg::WIDE_W-1:0]      back_prod;
	logic [rdc_pkg::WIDE_W-1:0]      rem_wide;
	logic [rdc_pkg::REM_W-1:0]       rem_raw;
	logic [rdc_pkg::REM_W-1:0]       rem_fix;
	logic [rdc_pkg::VALUE_BITS-1:0]  q_fix;
	logic                            last_digit;
	logic                            out_free;
	logic                            emit;

	assign rsp_valid  = rsp_valid_q;
	assign digit_char = char_q;
	assign is_last    = last_q;
	assign error_code = err_q;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign emit     = (state_q == ST_EMIT) && out_free;
	assign pop      = (state_q == ST_IDLE) && !qstat.empty;

	// Remainder from the estimated quotient, with one correction step
	always_comb begin
		q_est     = prod_q[rdc_pkg::PROD_W-1:rdc_pkg::RECIP_W];
		back_prod = rdc_pkg::WIDE_W'(q_est) * rdc_pkg::WIDE_W'(radix_q);
		rem_wide  = rdc_pkg::WIDE_W'(quot_q) - back_prod;
		rem_raw   = rem_wide[rdc_pkg::REM_W-1:0];
		if (rem_raw >= rdc_pkg::REM_W'(radix_q)) begin
			rem_fix = rem_raw - rdc_pkg::REM_W'(radix_q);
			q_fix   = q_est + rdc_pkg::VALUE_BITS'(1);
		end else begin
			rem_fix = rem_raw;
			q_fix   = q_est;
		end
		last_digit = (q_fix == '0) ||
			(cnt_q == rdc_pkg::CNT_W'(rdc_pkg::VALUE_BITS - 1));
	end

	// Digit store
	always_ff @(posedge clk) begin
		if (state_q == ST_REM) begin
			store_q[cnt_q[rdc_pkg::IDX_W-1:0]] <= rem_fix[rdc_pkg::DIGIT_W-1:0];
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			quot_q      <= pop_job.value;
			radix_q     <= pop_job.radix;
			spec_char_q <= (pop_job.kind == rdc_pkg::KIND_ZERO) ?
				rdc_pkg::CHAR_ZERO : rdc_pkg::CHAR_ERR;
			spec_err_q  <= (pop_job.kind == rdc_pkg::KIND_BAD) ?
				rdc_pkg::ERR_RADIX : rdc_pkg::ERR_NONE;
		end
		if (state_q == ST_MUL) begin
			prod_q <= rdc_pkg::PROD_W'(quot_q) *
				rdc_pkg::PROD_W'(rdc_pkg::recip_of(radix_q));
		end
		if (state_q == ST_REM) begin
			quot_q <= q_fix;
			if (last_digit) begin
				idx_q <= cnt_q[rdc_pkg::IDX_W-1:0];
			end
		end
		if (emit && !special_q && idx_q != '0) begin
			idx_q <= idx_q - rdc_pkg::IDX_W'(1);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			special_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cnt_q <= '0;
						if (pop_job.kind == rdc_pkg::KIND_NUM) begin
							special_q <= 1'b0;
							state_q   <= ST_MUL;
						end else begin
							special_q <= 1'b1;
							state_q   <= ST_EMIT;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					cnt_q   <= cnt_q + rdc_pkg::CNT_W'(1);
					state_q <= last_digit ? ST_EMIT : ST_MUL;
				end
				ST_EMIT: begin
					if (emit && (special_q || idx_q == '0)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			if (special_q) begin
				char_q <= spec_char_q;
				last_q <= 1'b1;
				err_q  <= spec_err_q;
			end else begin
				char_q <= rdc_pkg::glyph_of(store_q[idx_q]);
				last_q <= (idx_q == '0);
				err_q  <= rdc_pkg::ERR_NONE;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= emit;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rdc_pkg::CNT_W'(rdc_pkg::VALUE_BITS))
		else $error("back: digit count beyond store depth");

	a_rem_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REM |-> $past(state_q) == ST_MUL)
		else $error("back: remainder step without product");

	a_rem_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REM |-> rem_fix < rdc_pkg::REM_W'(radix_q))
		else $error("back: remainder not below radix after correction");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !special_q) |-> rdc_pkg::CNT_W'(idx_q) < cnt_q)
		else $error("back: read index past collected digits");

endmodule

`default_nettype wire

/* hdl/radix_digit_converter_unit.sv */
// Radix digit converter top level: front end, job queue and back end.
// Converts a non-negative integer into ASCII digits ('0'-'9', 'A'-'F') in radix 2 to 16,
// most significant digit first, one response word per character with is_last on the
// final one. A zero value gives the single word '0'; a nonzero value with a radix outside
// 2 to 16 gives one word with digit_char 0 and error_code 1. In the back end each digit takes
// a reciprocal multiply step, then a remainder and correction step, and each character then
// leaves at one per cycle through the output register while the output is not stalled.
// A two-entry queue lets request words be accepted while the back end is busy with an
// earlier one.
`default_nettype none

module radix_digit_converter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic [rdc_pkg::VALUE_BITS-1:0] value,
	input  wire logic [rdc_pkg::RADIX_W-1:0]    radix,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output logic [rdc_pkg::CHAR_W-1:0]          digit_char,
	output logic                                is_last,
	output logic                                error_code
);

	rdc_pkg::qstat_t qstat;
	rdc_pkg::job_t   push_job;
	rdc_pkg::job_t   pop_job;
	logic            push;
	logic            pop;

	rdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.value     (value),
		.radix     (radix),
		.qstat     (qstat),
		.push      (push),
		.push_job  (push_job)
	);

	rdc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.qstat    (qstat)
	);

	rdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_job    (pop_job),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.digit_char (digit_char),
		.is_last    (is_last),
		.error_code (error_code)
	);

endmodule

`default_nettype wire
